### design/trkseq_pkg.sv
package trkseq_pkg;

    // sizes of the song storage
    localparam int TRACKS      = 4;
    localparam int ROWS        = 64;
    localparam int PATTERNS    = 64;
    localparam int ORDER_DEPTH = 256;

    localparam int TRACK_W    = $clog2(TRACKS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int PAT_W      = $clog2(PATTERNS);
    localparam int ORD_W      = $clog2(ORDER_DEPTH);
    localparam int CELL_DEPTH = PATTERNS * ROWS * TRACKS;
    localparam int CELL_AW    = PAT_W + ROW_W + TRACK_W;

    // input commands
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_TOGGLE = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_CELL   = 3'd3;
    localparam logic [2:0] CMD_ORDER  = 3'd4;

    // event kinds
    localparam logic [1:0] EV_TRIGGER = 2'd0;
    localparam logic [1:0] EV_STOP    = 2'd1;
    localparam logic [1:0] EV_SILENCE = 2'd2;

    // config register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TEMPO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_CODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE   = 3'd4;

    // config reset values
    localparam logic [8:0] ORDER_LENGTH_RST = 9'd1;
    localparam logic [7:0] TEMPO_RST        = 8'd6;
    localparam logic [7:0] SPEED_CODE_RST   = 8'd15;
    localparam logic [7:0] CUT_CODE_RST     = 8'd12;
    localparam logic [7:0] EMPTY_CODE_RST   = 8'd0;

    typedef struct packed {
        logic [7:0] param;
        logic [7:0] effect;
        logic [7:0] instrument;
        logic [7:0] note;
    } cell_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] channel;
        logic [7:0] note;
        logic [7:0] instrument;
    } event_t;

    typedef struct packed {
        logic   speed_hit;
        logic   ev_valid;
        event_t ev;
    } cell_eval_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ORDER = 4'b0010,
        S_CELL  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

endpackage

### design/trkseq_ram.sv
module trkseq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/trkseq_cell_eval.sv
module trkseq_cell_eval import trkseq_pkg::*; (
    input  cell_t               cell_in,
    input  logic [TRACK_W-1:0]  track,
    input  logic [7:0]          speed_code,
    input  logic [7:0]          cut_code,
    input  logic [7:0]          empty_code,
    output cell_eval_t          result
);

    logic is_cut;
    logic has_note;

    assign is_cut   = (cell_in.effect == cut_code);
    assign has_note = (cell_in.note != empty_code);

    always_comb begin
        result.speed_hit     = (cell_in.effect == speed_code) && (cell_in.param != 8'd0);
        result.ev_valid      = is_cut || has_note;
        result.ev.channel    = 2'(track);
        // cut wins over a note in the same cell
        if (is_cut) begin
            result.ev.kind       = EV_STOP;
            result.ev.note       = 8'd0;
            result.ev.instrument = 8'd0;
        end else begin
            result.ev.kind       = EV_TRIGGER;
            result.ev.note       = cell_in.note;
            result.ev.instrument = cell_in.instrument;
        end
    end

endmodule

### design/tracker_pattern_sequencer.sv
// Tracker pattern sequencer: playback engine for a four-track song.
// Input stream (s_*): one command word per handshake. Commands load pattern
// cells and order entries, start/stop playback, and deliver frame ticks.
// Output stream (m_*): note events (trigger, channel stop, silence all);
// m_tlast marks the final event caused by one input word.
// Config port: cfg_wr_en/cfg_index/cfg_wr_data, one register per write, to be
// written only while idle; the block itself does not enforce this.
// Steps: writes, toggles into play and ticks that do not finish a row finish
// on acceptance. Stop and toggle out of play also pass the flush state. A tick
// that ends a row steps through accept, order table read, one pattern RAM read
// per track and a final flush/row-advance state. The single read port of the
// pattern RAM, one cell per cycle unless the output stalls, sets this pace.
// Events are held in a one-deep pending register plus the output register,
// so a row stalls only when the receiver holds off m_tready while both are
// full; the last event of a row waits in the flush state.
// Reset (aresetn low, synchronous): playback stopped, order and row
// positions zero, tempo 6, countdown 1, config registers to defaults.
// Pattern and order memories are not cleared; read only what was written.
module tracker_pattern_sequencer import trkseq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: command[2:0], pattern_sel[8:3], row_sel[14:9], track_sel[16:15],
    //          note_in[24:17], instrument_in[32:25], effect_in[40:33],
    //          param_in[48:41], order_pos[56:49], zero[63:57]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,
    // m_tdata: event_kind[1:0], channel[3:2], note_out[11:4],
    //          instrument_out[19:12], zero[23:20]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // input word fields
    logic [2:0]   in_cmd;
    logic [PAT_W-1:0] in_pattern;
    logic [ROW_W-1:0] in_row;
    logic [TRACK_W-1:0] in_track;
    cell_t        in_cell;
    logic [ORD_W-1:0] in_order_pos;

    assign in_cmd             = s_tdata[2:0];
    assign in_pattern         = s_tdata[8:3];
    assign in_row             = s_tdata[14:9];
    assign in_track           = s_tdata[16:15];
    assign in_cell.note       = s_tdata[24:17];
    assign in_cell.instrument = s_tdata[32:25];
    assign in_cell.effect     = s_tdata[40:33];
    assign in_cell.param      = s_tdata[48:41];
    assign in_order_pos       = s_tdata[56:49];

    // state
    state_t             state_reg, state_next;
    logic               playing_reg, playing_next;
    logic [ORD_W-1:0]   order_pos_reg, order_pos_next;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [7:0]         fpr_reg, fpr_next;
    logic [7:0]         frames_left_reg, frames_left_next;
    logic [TRACK_W-1:0] track_reg, track_next;
    logic [PAT_W-1:0]   pat_reg, pat_next;
    logic               run_row_reg, run_row_next;
    logic               pend_valid_reg, pend_valid_next;
    event_t             pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    event_t             m_event_reg, m_event_next;
    logic               m_last_reg, m_last_next;

    // config
    logic [8:0]         order_len_reg, order_len_next;
    logic [7:0]         speed_code_reg, speed_code_next;
    logic [7:0]         cut_code_reg, cut_code_next;
    logic [7:0]         empty_code_reg, empty_code_next;

    // memory ports
    logic               ord_wr_en, ord_rd_en;
    logic [PAT_W-1:0]   ord_rd_data;
    logic               cell_wr_en, cell_rd_en;
    logic [CELL_AW-1:0] cell_wr_addr, cell_rd_addr;
    logic [31:0]        cell_rd_data;
    cell_t              cell_q;
    cell_eval_t         eval;

    logic               s_accept;
    logic               out_free;
    logic               advance;
    logic               push;
    logic               push_last;
    logic [7:0]         frames_dec;
    logic [8:0]         used_len;
    logic [8:0]         order_inc;
    logic [PAT_W-1:0]   rd_pat;
    logic [TRACK_W-1:0] rd_track;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_event_reg.instrument, m_event_reg.note,
                       m_event_reg.channel, m_event_reg.kind};

    trkseq_ram #(
        .WIDTH (PAT_W),
        .DEPTH (ORDER_DEPTH)
    ) u_order_ram (
        .aclk    (aclk),
        .wr_en   (ord_wr_en),
        .wr_addr (in_order_pos),
        .wr_data (in_pattern),
        .rd_en   (ord_rd_en),
        .rd_addr (order_pos_reg),
        .rd_data (ord_rd_data)
    );

    assign cell_wr_addr = {in_pattern, in_row, in_track};
    assign rd_pat       = (state_reg == S_ORDER) ? ord_rd_data : pat_reg;
    assign rd_track     = (state_reg == S_ORDER) ? '0 : track_reg + TRACK_W'(1);
    assign cell_rd_addr = {rd_pat, row_pos_reg, rd_track};

    trkseq_ram #(
        .WIDTH (32),
        .DEPTH (CELL_DEPTH)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (cell_wr_en),
        .wr_addr (cell_wr_addr),
        .wr_data (in_cell),
        .rd_en   (cell_rd_en),
        .rd_addr (cell_rd_addr),
        .rd_data (cell_rd_data)
    );

    assign cell_q = cell_t'(cell_rd_data);

    // shared per-cell compare unit, one track per cycle unless the output stalls
    trkseq_cell_eval u_eval (
        .cell_in    (cell_q),
        .track      (track_reg),
        .speed_code (speed_code_reg),
        .cut_code   (cut_code_reg),
        .empty_code (empty_code_reg),
        .result     (eval)
    );

    // a new event pushes the older pending one out; stall if both are full
    assign advance    = !(eval.ev_valid && pend_valid_reg) || out_free;
    assign frames_dec = (frames_left_reg == 8'd0) ? 8'd0 : frames_left_reg - 8'd1;

    // effective order length: 0 acts as 1, clamp to table depth
    always_comb begin
        if (order_len_reg == 9'd0) begin
            used_len = 9'd1;
        end else if (order_len_reg > 9'(ORDER_DEPTH)) begin
            used_len = 9'(ORDER_DEPTH);
        end else begin
            used_len = order_len_reg;
        end
    end
    assign order_inc = {1'b0, order_pos_reg} + 9'd1;

    always_comb begin
        state_next       = state_reg;
        playing_next     = playing_reg;
        order_pos_next   = order_pos_reg;
        row_pos_next     = row_pos_reg;
        fpr_next         = fpr_reg;
        frames_left_next = frames_left_reg;
        track_next       = track_reg;
        pat_next         = pat_reg;
        run_row_next     = run_row_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_event_next     = m_event_reg;
        m_last_next      = m_last_reg;
        order_len_next   = order_len_reg;
        speed_code_next  = speed_code_reg;
        cut_code_next    = cut_code_reg;
        empty_code_next  = empty_code_reg;
        ord_wr_en        = 1'b0;
        ord_rd_en        = 1'b0;
        cell_wr_en       = 1'b0;
        cell_rd_en       = 1'b0;
        push             = 1'b0;
        push_last        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    case (in_cmd)
                        CMD_TICK: begin
                            if (playing_reg) begin
                                frames_left_next = frames_dec;
                                if (frames_dec == 8'd0) begin
                                    ord_rd_en    = 1'b1;
                                    run_row_next = 1'b1;
                                    state_next   = S_ORDER;
                                end
                            end
                        end
                        CMD_TOGGLE: begin
                            playing_next = !playing_reg;
                            if (playing_reg) begin
                                pend_next       = '{kind: EV_SILENCE, default: '0};
                                pend_valid_next = 1'b1;
                                run_row_next    = 1'b0;
                                state_next      = S_FLUSH;
                            end else begin
                                frames_left_next = 8'd1;
                            end
                        end
                        CMD_STOP: begin
                            playing_next     = 1'b0;
                            order_pos_next   = '0;
                            row_pos_next     = '0;
                            frames_left_next = fpr_reg;
                            pend_next        = '{kind: EV_SILENCE, default: '0};
                            pend_valid_next  = 1'b1;
                            run_row_next     = 1'b0;
                            state_next       = S_FLUSH;
                        end
                        CMD_CELL:  cell_wr_en = 1'b1;
                        CMD_ORDER: ord_wr_en  = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_ORDER: begin
                pat_next   = ord_rd_data;
                track_next = '0;
                cell_rd_en = 1'b1;
                state_next = S_CELL;
            end
            S_CELL: begin
                if (advance) begin
                    if (eval.speed_hit) begin
                        fpr_next = cell_q.param;
                    end
                    if (eval.ev_valid) begin
                        push            = pend_valid_reg;
                        pend_next       = eval.ev;
                        pend_valid_next = 1'b1;
                    end
                    if (track_reg == TRACK_W'(TRACKS - 1)) begin
                        state_next = S_FLUSH;
                    end else begin
                        track_next = track_reg + TRACK_W'(1);
                        cell_rd_en = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    push            = pend_valid_reg;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    if (run_row_reg) begin
                        // countdown reload uses the tempo after this row's effects
                        frames_left_next = fpr_reg;
                        if (row_pos_reg == ROW_W'(ROWS - 1)) begin
                            row_pos_next = '0;
                            if (order_inc >= used_len) begin
                                order_pos_next = '0;
                            end else begin
                                order_pos_next = order_inc[ORD_W-1:0];
                            end
                        end else begin
                            row_pos_next = row_pos_reg + ROW_W'(1);
                        end
                    end
                    run_row_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (push) begin
            m_valid_next = 1'b1;
            m_event_next = pend_reg;
            m_last_next  = push_last;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ORDER_LENGTH: order_len_next  = cfg_wr_data;
                CFG_INIT_TEMPO:   fpr_next        = cfg_wr_data[7:0];
                CFG_SPEED_CODE:   speed_code_next = cfg_wr_data[7:0];
                CFG_CUT_CODE:     cut_code_next   = cfg_wr_data[7:0];
                CFG_EMPTY_CODE:   empty_code_next = cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            playing_reg     <= 1'b0;
            order_pos_reg   <= '0;
            row_pos_reg     <= '0;
            fpr_reg         <= TEMPO_RST;
            frames_left_reg <= 8'd1;
            track_reg       <= '0;
            run_row_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
            order_len_reg   <= ORDER_LENGTH_RST;
            speed_code_reg  <= SPEED_CODE_RST;
            cut_code_reg    <= CUT_CODE_RST;
            empty_code_reg  <= EMPTY_CODE_RST;
        end else begin
            state_reg       <= state_next;
            playing_reg     <= playing_next;
            order_pos_reg   <= order_pos_next;
            row_pos_reg     <= row_pos_next;
            fpr_reg         <= fpr_next;
            frames_left_reg <= frames_left_next;
            track_reg       <= track_next;
            run_row_reg     <= run_row_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
            order_len_reg   <= order_len_next;
            speed_code_reg  <= speed_code_next;
            cut_code_reg    <= cut_code_next;
            empty_code_reg  <= empty_code_next;
        end
        pat_reg     <= pat_next;
        pend_reg    <= pend_next;
        m_event_reg <= m_event_next;
        m_last_reg  <= m_last_next;
    end

`ifndef NO_ASSERTIONS
    // a row only runs while playing
    a_row_while_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ORDER) |-> playing_reg)
        else $error("row run started while stopped");

    // stop always leaves playback off with positions cleared
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_cmd == CMD_STOP) |=>
            (!playing_reg && order_pos_reg == '0 && row_pos_reg == '0))
        else $error("stop did not reset playback");

    // silence is always the only, hence final, word of its command
    a_silence_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_event_reg.kind == EV_SILENCE) |-> m_last_reg)
        else $error("silence event without last");

    // the pending event is never overwritten while output is blocked
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CELL && eval.ev_valid && pend_valid_reg && !out_free)
            |=> ($stable(pend_reg) && state_reg == S_CELL))
        else $error("pending event overrun");
`endif

endmodule

### dv/tb_top.sv
module tb_top;
    import trkseq_pkg::*;

    // Unused command codes; the block must swallow them without a word out.
    localparam logic [2:0] CMD_NONE_LO = 3'd5;
    localparam logic [2:0] CMD_NONE_HI = 3'd7;

    // Fixed run limit, far above the slowest legal run.
    localparam int LIMIT_CYCLES = 800_000;
    // Long receiver hold-off, enough to back the block up into its input.
    localparam int HOLD_CYCLES  = 300;
    // Quiet time after the last due event.
    localparam int SETTLE_CYCLES = 16;

    // One command word, packed as on s_tdata (last field in the low bits).
    typedef struct packed {
        logic [6:0] pad;
        logic [7:0] order_pos;
        logic [7:0] param;
        logic [7:0] effect;
        logic [7:0] instrument;
        logic [7:0] note;
        logic [1:0] track;
        logic [5:0] row;
        logic [5:0] pattern;
        logic [2:0] command;
    } cmd_word_t;

    typedef struct packed {
        event_t ev;
        logic   last;
    } due_event_t;

    // How a directed row is checked: by the predictor, or by a value typed in.
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_EVENT,
        SILENCE_ONLY
    } row_check_t;

    typedef struct packed {
        cmd_word_t  word;
        row_check_t check;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    tracker_pattern_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sequencer predictor: registers, playback state and song memory
    // ------------------------------------------------------------------
    logic [8:0] order_len  = ORDER_LENGTH_RST;
    logic [7:0] speed_code = SPEED_CODE_RST;
    logic [7:0] cut_code   = CUT_CODE_RST;
    logic [7:0] empty_code = EMPTY_CODE_RST;

    bit         playing     = 1'b0;
    logic [7:0] order_idx   = '0;
    logic [5:0] row_idx     = '0;
    logic [7:0] fpr         = TEMPO_RST;   // frames per row in force
    logic [7:0] frames_left = 8'd1;

    cell_t      song_cells [PATTERNS][ROWS][TRACKS];
    bit         cell_known [PATTERNS][ROWS][TRACKS];
    logic [5:0] order_list [ORDER_DEPTH];
    bit         order_known [ORDER_DEPTH];

    due_event_t word_events [$];   // events of the word just predicted
    due_event_t events_due [$];    // events predicted but not yet seen
    stim_row_t  dir_tab [$];

    int         mismatches = 0;
    bit         quiet = 1'b0;      // no idling on either side
    bit         hold_req = 1'b0;
    logic [5:0] fill_pats [2];     // patterns used when filling order entries

    function automatic void add_event(logic [1:0] kind, logic [1:0] ch,
                                      logic [7:0] note, logic [7:0] inst);
        due_event_t d;
        d.ev.kind       = kind;
        d.ev.channel    = ch;
        d.ev.note       = note;
        d.ev.instrument = inst;
        d.last          = 1'b0;
        word_events.push_back(d);
    endfunction

    // Advances the predictor by one command word; events land in word_events.
    function automatic void apply_command(cmd_word_t w);
        int         used;
        logic [5:0] pat;
        cell_t      c;
        word_events.delete();
        case (w.command)
            CMD_TICK: begin
                if (playing) begin
                    if (frames_left != 0) frames_left--;
                    if (frames_left == 0) begin
                        // row due: walk every track of the current row
                        pat = order_list[order_idx];
                        for (int t = 0; t < TRACKS; t++) begin
                            c = song_cells[pat][row_idx][t];
                            if (c.effect == speed_code && c.param != 0) begin
                                fpr = c.param;
                                if (frames_left > c.param) frames_left = c.param;
                            end
                            if (c.effect == cut_code)
                                add_event(EV_STOP, 2'(t), 8'd0, 8'd0);
                            else if (c.note != empty_code)
                                add_event(EV_TRIGGER, 2'(t), c.note, c.instrument);
                        end
                        // 0 acts as 1, anything past the table as its depth
                        used = (order_len == 0) ? 1 :
                               (order_len > ORDER_DEPTH) ? ORDER_DEPTH : int'(order_len);
                        if (row_idx == 6'(ROWS - 1)) begin
                            row_idx = '0;
                            if (int'(order_idx) + 1 >= used) begin
                                order_idx = '0;
                            end else begin
                                order_idx++;
                            end
                        end else begin
                            row_idx++;
                        end
                        frames_left = fpr;
                    end
                end
            end
            CMD_TOGGLE: begin
                playing = !playing;
                if (playing) frames_left = 8'd1;
                else add_event(EV_SILENCE, 2'd0, 8'd0, 8'd0);
            end
            CMD_STOP: begin
                playing     = 1'b0;
                order_idx   = '0;
                row_idx     = '0;
                frames_left = fpr;
                add_event(EV_SILENCE, 2'd0, 8'd0, 8'd0);
            end
            CMD_CELL: begin
                song_cells[w.pattern][w.row][w.track] = {w.param, w.effect, w.instrument, w.note};
                cell_known[w.pattern][w.row][w.track] = 1'b1;
            end
            CMD_ORDER: begin
                order_list[w.order_pos]  = w.pattern;
                order_known[w.order_pos] = 1'b1;
            end
            default: ;
        endcase
        if (word_events.size() != 0) word_events[word_events.size() - 1].last = 1'b1;
    endfunction

    function automatic cmd_word_t make_word(logic [2:0] cmd, logic [5:0] pat, logic [5:0] rw,
                                            logic [1:0] trk, logic [7:0] note, logic [7:0] inst,
                                            logic [7:0] eff, logic [7:0] par, logic [7:0] opos);
        cmd_word_t w;
        w            = '0;
        w.command    = cmd;
        w.pattern    = pat;
        w.row        = rw;
        w.track      = trk;
        w.note       = note;
        w.instrument = inst;
        w.effect     = eff;
        w.param      = par;
        w.order_pos  = opos;
        return w;
    endfunction

    function automatic cmd_word_t random_word(logic [2:0] cmd);
        cmd_word_t w;
        w         = {$urandom, $urandom};
        w.pad     = '0;
        w.command = cmd;
        return w;
    endfunction

    function automatic void add_row(cmd_word_t w, row_check_t chk);
        stim_row_t r;
        r.word  = w;
        r.check = chk;
        dir_tab.push_back(r);
    endfunction

    // A tick, unless the row it would play touches memory never written:
    // then the missing order entry or cell is written first.
    function automatic cmd_word_t tick_or_fill();
        cmd_word_t  w;
        logic [5:0] pat;
        int         r;
        w = random_word(CMD_TICK);
        if (!playing || frames_left > 1) return w;
        if (!order_known[order_idx]) begin
            w           = random_word(CMD_ORDER);
            w.order_pos = order_idx;
            w.pattern   = fill_pats[$urandom_range(0, 1)];
            return w;
        end
        pat = order_list[order_idx];
        for (int t = 0; t < TRACKS; t++) begin
            if (!cell_known[pat][row_idx][t]) begin
                w         = random_word(CMD_CELL);
                w.pattern = pat;
                w.row     = row_idx;
                w.track   = 2'(t);
                r = $urandom_range(0, 99);
                if (r < 20) w.effect = speed_code;
                else if (r < 35) w.effect = cut_code;
                // keep tempo low so rows keep coming
                if (w.effect == speed_code) w.param = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) w.note = empty_code;
                return w;
            end
        end
        return w;
    endfunction

    // Song mode: play straight through, only ticks and the fills they need.
    function automatic cmd_word_t pick_word(bit song);
        int r;
        r = $urandom_range(0, 99);
        if (!playing && (song || r < 70)) return random_word(CMD_TOGGLE);
        if (song || r < 62) return tick_or_fill();
        if (r < 72) return random_word(CMD_CELL);
        if (r < 78) return random_word(CMD_ORDER);
        if (r < 84) return random_word(CMD_TOGGLE);
        if (r < 89) return random_word(CMD_STOP);
        if (r < 94) return random_word(3'($urandom_range(CMD_NONE_LO, CMD_NONE_HI)));
        return tick_or_fill();
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // Predict, then offer the word until the block takes it.
    task automatic issue(cmd_word_t w, row_check_t chk);
        due_event_t sil;
        apply_command(w);
        case (chk)
            BY_MODEL: foreach (word_events[k]) events_due.push_back(word_events[k]);
            SILENCE_ONLY: begin
                sil      = '0;
                sil.ev.kind = EV_SILENCE;
                sil.last = 1'b1;
                events_due.push_back(sil);
            end
            default: ;
        endcase
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sender_gap();
    endtask

    // Idle the input and let every due event come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (events_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_ORDER_LENGTH: order_len = val;
            CFG_INIT_TEMPO:   fpr = val[7:0];   // tempo write takes effect at once
            CFG_SPEED_CODE:   speed_code = val[7:0];
            CFG_CUT_CODE:     cut_code   = val[7:0];
            CFG_EMPTY_CODE:   empty_code = val[7:0];
            default: ;
        endcase
    endtask

    // One random phase under a fresh register setting.
    task automatic run_phase(logic [8:0] len, logic [7:0] tempo, logic [7:0] spd,
                             logic [7:0] cut, logic [7:0] emp, int words, bit song);
        int        done;
        cmd_word_t w;
        settle();
        write_reg(CFG_ORDER_LENGTH, len);
        write_reg(CFG_INIT_TEMPO, 9'(tempo));
        write_reg(CFG_SPEED_CODE, 9'(spd));
        write_reg(CFG_CUT_CODE, 9'(cut));
        write_reg(CFG_EMPTY_CODE, 9'(emp));
        fill_pats[0] = 6'($urandom_range(0, PATTERNS - 1));
        fill_pats[1] = 6'($urandom_range(0, PATTERNS - 1));
        done = 0;
        while (done < words) begin
            w = pick_word(song);
            if (w.command <= CMD_ORDER) done++;
            // back the block up once while rows are producing events
            if (song && done == 30) hold_req = 1'b1;
            issue(w, BY_MODEL);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, one long hold-off, and the checker
    // ------------------------------------------------------------------
    int rx_gap = 0;
    int hold_left = 0;

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic void take_event(logic [23:0] d, logic lst);
        due_event_t want;
        if (events_due.size() == 0) begin
            $display("%0t: event with none due, expected nothing, got data %h last %b",
                     $time, d, lst);
            mismatches++;
            return;
        end
        want = events_due.pop_front();
        check_field("event_kind", 8'(want.ev.kind), 8'(d[1:0]));
        check_field("channel", 8'(want.ev.channel), 8'(d[3:2]));
        check_field("note_out", want.ev.note, d[11:4]);
        check_field("instrument_out", want.ev.instrument, d[19:12]);
        check_field("last", 8'(want.last), 8'(lst));
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) take_event(m_tdata, m_tlast);
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words at reset settings (speed 15, cut 12, empty 0).
        // Pattern 63 rows 0 and 1 are loaded and played through order entry 0.
        add_row(make_word(CMD_TICK, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                NO_EVENT);      // tick while stopped
        add_row(make_word(CMD_STOP, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                SILENCE_ONLY);  // stop while already stopped
        add_row(make_word(CMD_ORDER, 6'd63, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                NO_EVENT);
        add_row(make_word(CMD_ORDER, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF),
                NO_EVENT);
        // row 0: full-scale trigger, cut, speed 255 on an empty note,
        // zero-param speed beside a real note
        add_row(make_word(CMD_CELL, 6'd63, 6'd0, 2'd0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'd0),
                NO_EVENT);
        add_row(make_word(CMD_CELL, 6'd63, 6'd0, 2'd1, 8'h05, 8'hA5, CUT_CODE_RST, 8'h00, 8'd0),
                NO_EVENT);
        add_row(make_word(CMD_CELL, 6'd63, 6'd0, 2'd2, EMPTY_CODE_RST, 8'h11, SPEED_CODE_RST,
                          8'hFF, 8'd0), NO_EVENT);
        add_row(make_word(CMD_CELL, 6'd63, 6'd0, 2'd3, 8'h01, 8'h00, SPEED_CODE_RST, 8'h00,
                          8'd0), NO_EVENT);
        // row 1: one trigger, two empties, a cut on the top track
        add_row(make_word(CMD_CELL, 6'd63, 6'd1, 2'd0, 8'h80, 8'h5A, 8'h80, 8'h3C, 8'd0),
                NO_EVENT);
        add_row(make_word(CMD_CELL, 6'd63, 6'd1, 2'd1, EMPTY_CODE_RST, 8'h00, 8'h00, 8'h00,
                          8'd0), NO_EVENT);
        add_row(make_word(CMD_CELL, 6'd63, 6'd1, 2'd2, EMPTY_CODE_RST, 8'hFF, 8'hFF, 8'hFF,
                          8'd0), NO_EVENT);
        add_row(make_word(CMD_CELL, 6'd63, 6'd1, 2'd3, EMPTY_CODE_RST, 8'h00, CUT_CODE_RST,
                          8'h00, 8'd0), NO_EVENT);
        add_row(make_word(CMD_NONE_HI, 6'd63, 6'd63, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                NO_EVENT);      // unused command, all fields high
        add_row(make_word(CMD_TOGGLE, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                NO_EVENT);      // into play: countdown of one
        add_row(make_word(CMD_TICK, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                BY_MODEL);      // row 0 plays
        add_row(make_word(CMD_TICK, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                BY_MODEL);      // tempo now 255, just counts
        add_row(make_word(CMD_TOGGLE, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                SILENCE_ONLY);  // out of play
        add_row(make_word(CMD_TOGGLE, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                NO_EVENT);
        add_row(make_word(CMD_TICK, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                BY_MODEL);      // row 1 plays
        add_row(make_word(CMD_STOP, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                SILENCE_ONLY);
        add_row(make_word(CMD_NONE_LO, 6'd0, 6'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                NO_EVENT);

        foreach (dir_tab[i]) issue(dir_tab[i].word, dir_tab[i].check);

        // Random phases; register extremes spread over them.
        run_phase(9'd0,   8'd0,   8'd15, 8'd12,  8'd0,   40, 1'b0);  // length 0 acts as 1
        run_phase(9'd2,   8'd1,   8'd0,  8'd255, 8'd255, 40, 1'b1);  // song: ticks and fills
        run_phase(9'd256, 8'd255, 8'd7,  8'd7,   8'd128, 30, 1'b0);  // speed and cut share a code
        quiet = 1'b1;
        run_phase(9'd1,   8'd3,   8'd15, 8'd12,  8'd0,   30, 1'b0);

        settle();
        if (mismatches == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(12 * LIMIT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
